FILE: hdl/sss_pkg.sv
`default_nettype none

package sss_pkg;

  // Default store depth
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned MEAN_W   = 24;

  // Quotient width of the mean divider for a given depth
  function automatic int unsigned quot_width(input int unsigned cap);
    return SAMPLE_W + $clog2(cap) + FRAC_W;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sss_ram.sv
`default_nettype none

module sss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/sss_div.sv
`default_nettype none

module sss_div #(
  parameter int unsigned QW   = sss_pkg::quot_width(sss_pkg::CAPACITY_DEF),
  parameter int unsigned DV_W = $clog2(sss_pkg::CAPACITY_DEF + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [QW-1:0]     dividend_i,
  input  wire [DV_W-1:0]   divisor_i,
  output logic             done_o,
  output logic [QW-1:0]    quotient_o
);

  import sss_pkg::*;

  localparam int unsigned CW = (QW > 1) ? $clog2(QW) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DV_W-1:0] rem_q, rem_d;
  logic [DV_W-1:0] dvs_q, dvs_d;
  logic [QW-1:0]   dq_q, dq_d;

  logic [DV_W:0]   rem_sh;
  logic [DV_W:0]   diff;
  logic            ge;

  // Restoring step: one quotient bit per cycle
  assign rem_sh = {rem_q, dq_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DV_W-1:0] : rem_sh[DV_W-1:0];
      dq_d  = {dq_q[QW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

  // Done only follows a running divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running divide");

  // Remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(start_i) && dvs_q != '0 |-> rem_q < dvs_q)
    else $error("divider remainder out of range");

  // Start is not issued while a divide runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: hdl/sorted_sample_store_with_stats_top.sv
`default_nettype none
// Each stored request moves the entries above the new sample up one slot, each by a
//   RAM read and a RAM write, then reads the statistics while the serial mean divider
//   runs; done_o strobes when both are through, and busy_o is high until then.
// A dropped request (store full) strobes its result in the next cycle; busy_o stays low.
// Reset: rst_ni clears count, sum and control, not the RAM; results cannot stall.

module sorted_sample_store_with_stats_top #(
  parameter int unsigned CAPACITY = sss_pkg::CAPACITY_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire [sss_pkg::SAMPLE_W-1:0]        sample_i,
  output logic                               done_o,
  output logic                               dropped_o,
  output logic [$clog2(CAPACITY+1)-1:0]      count_o,
  output logic [sss_pkg::MEAN_W-1:0]         mean_q8_o,
  output logic [sss_pkg::SAMPLE_W-1:0]       median_o,
  output logic [sss_pkg::SAMPLE_W-1:0]       minimum_o,
  output logic [sss_pkg::SAMPLE_W-1:0]       maximum_o
);

  import sss_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(CAPACITY);
  localparam int unsigned QW    = quot_width(CAPACITY);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SH_RD  = 3'd1;
  localparam logic [2:0] ST_SH_CMP = 3'd2;
  localparam logic [2:0] ST_PUT    = 3'd3;
  localparam logic [2:0] ST_RD     = 3'd4;

  // Statistic read steps
  localparam logic [2:0] RD_MIN  = 3'd0;
  localparam logic [2:0] RD_MAX  = 3'd1;
  localparam logic [2:0] RD_HI   = 3'd2;
  localparam logic [2:0] RD_LO   = 3'd3;
  localparam logic [2:0] RD_LAST = 3'd4;
  localparam logic [2:0] RD_FIN  = 3'd5;

  logic [2:0]          st_q, st_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [SAMPLE_W-1:0] smp_q, smp_d;
  logic [2:0]          rd_q, rd_d;
  logic                mrdy_q, mrdy_d;
  logic                done_q, done_d;
  logic                drop_q, drop_d;
  logic [MEAN_W-1:0]   mean_q, mean_d;
  logic [SAMPLE_W-1:0] med_q, med_d;
  logic [SAMPLE_W-1:0] min_q, min_d;
  logic [SAMPLE_W-1:0] max_q, max_d;
  logic [SAMPLE_W-1:0] hi_q, hi_d;
  logic [SAMPLE_W-1:0] lo_q, lo_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       div_quot;
  logic [CNT_W-1:0]    half;
  logic [SAMPLE_W:0]   mid_sum;

  assign half    = cnt_q >> 1;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  sss_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sss_div #(
    .QW   (QW),
    .DV_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q, FRAC_W'(0)}),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer: insert from the top down, then read statistics while dividing; drop when full
  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    pos_d     = pos_q;
    smp_d     = smp_q;
    rd_d      = rd_q;
    mrdy_d    = mrdy_q;
    done_d    = 1'b0;
    drop_d    = drop_q;
    mean_d    = mean_q;
    med_d     = med_q;
    min_d     = min_q;
    max_d     = max_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q[AW-1:0];
    ram_wdata = smp_q;
    ram_raddr = '0;
    div_start = 1'b0;

    if (div_done) begin
      mean_d = div_quot[MEAN_W-1:0];
      mrdy_d = 1'b1;
    end

    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cnt_q == CNT_W'(CAPACITY)) begin
            // Store full: repeat held statistics, flagged
            done_d = 1'b1;
            drop_d = 1'b1;
          end else begin
            smp_d  = sample_i;
            pos_d  = cnt_q;
            cnt_d  = cnt_q + 1'b1;
            sum_d  = sum_q + SUM_W'(sample_i);
            drop_d = 1'b0;
            st_d   = (cnt_q == '0) ? ST_PUT : ST_SH_RD;
          end
        end
      end
      ST_SH_RD: begin
        ram_raddr = AW'(pos_q - 1'b1);
        st_d      = ST_SH_CMP;
      end
      ST_SH_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata > smp_q) begin
          // Entry moves up one slot
          ram_wdata = ram_rdata;
          pos_d     = pos_q - 1'b1;
          st_d      = (pos_q == CNT_W'(1)) ? ST_PUT : ST_SH_RD;
        end else begin
          div_start = 1'b1;
          mrdy_d    = 1'b0;
          rd_d      = RD_MIN;
          st_d      = ST_RD;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
        mrdy_d    = 1'b0;
        rd_d      = RD_MIN;
        st_d      = ST_RD;
      end
      ST_RD: begin
        // Issue address for this step
        case (rd_q)
          RD_MIN:  ram_raddr = '0;
          RD_MAX:  ram_raddr = AW'(cnt_q - 1'b1);
          RD_HI:   ram_raddr = AW'(half);
          RD_LO:   ram_raddr = cnt_q[0] ? AW'(half) : AW'(half - 1'b1);
          default: ram_raddr = '0;
        endcase
        // Capture data of the previous step
        case (rd_q)
          RD_MAX:  min_d = ram_rdata;
          RD_HI:   max_d = ram_rdata;
          RD_LO:   hi_d  = ram_rdata;
          RD_LAST: lo_d  = ram_rdata;
          default: ;
        endcase
        if (rd_q != RD_FIN) begin
          rd_d = rd_q + 1'b1;
        end else if (mrdy_q || div_done) begin
          med_d  = cnt_q[0] ? hi_q : mid_sum[SAMPLE_W:1];
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      sum_q  <= '0;
      rd_q   <= RD_MIN;
      mrdy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      rd_q   <= rd_d;
      mrdy_q <= mrdy_d;
      done_q <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    smp_q  <= smp_d;
    drop_q <= drop_d;
    mean_q <= mean_d;
    med_q  <= med_d;
    min_q  <= min_d;
    max_q  <= max_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
  end

  assign busy_o    = (st_q != ST_IDLE);
  assign done_o    = done_q;
  assign dropped_o = drop_q;
  assign count_o   = cnt_q;
  assign mean_q8_o = mean_q;
  assign median_o  = med_q;
  assign minimum_o = min_q;
  assign maximum_o = max_q;

  // Count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A dropped request reports a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && drop_q |-> cnt_q == CNT_W'(CAPACITY))
    else $error("drop reported on a store that is not full");

  // A stored request finishes from the statistic read phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !drop_q |-> $past(st_q) == ST_RD && st_q == ST_IDLE)
    else $error("result strobe outside the read phase");

  // Shift loop never reads below the first entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SH_RD |-> pos_q != '0 && $past(st_q) != ST_RD)
    else $error("shift read at an empty position");

endmodule

`default_nettype wire
